// ===== sv/racorr_pkg.sv =====
// ----------------------------------------------------------------------------
// racorr_pkg
// Shared types and constants for the running autocorrelation block.
// ----------------------------------------------------------------------------
package racorr_pkg;

	localparam int VALUE_WIDTH = 48;
	localparam int FRAC_BITS   = 30;

	// register indexes
	localparam logic [3:0] REG_MAX_LAG   = 4'd0;
	localparam logic [3:0] REG_NORMALIZE = 4'd1;
	localparam logic [3:0] REG_SKIP_LAG0 = 4'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_MAC_RD,
		ST_MAC,
		ST_EMIT_RD,
		ST_EMIT,
		ST_DIV,
		ST_OUT
	} racorr_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic take_item;   // latch input item
		logic clear_step;  // clear one channel row entry
		logic mem_read;    // registered memory read at lag counter
		logic mac_step;    // one multiply-accumulate at lag counter
		logic emit_read;   // take read accumulator for output
		logic div_start;   // start divider
		logic out_load;    // load output register
		logic lag_clr;     // reset lag counter
		logic lag_inc;     // advance lag counter
	} racorr_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic lag_done;    // lag counter at effective max lag
		logic slice_end;   // latched slice end flag
		logic restart;     // latched restart flag
		logic need_div;    // current emitted value needs division
		logic div_busy;    // divider still working
		logic ch_ok;       // channel within range
	} racorr_sts_t;

endpackage

// ===== sv/racorr_div.sv =====
// ----------------------------------------------------------------------------
// racorr_div
// Restoring divider, one quotient bit per cycle: (|a| << 30) / b, saturated.
// ----------------------------------------------------------------------------
module racorr_div #(
	parameter int ACC_WIDTH = 48
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [ACC_WIDTH-1:0]         num,
	input  logic signed [ACC_WIDTH-1:0]         den,
	output logic                                busy,
	output logic signed [racorr_pkg::VALUE_WIDTH-1:0] result
);
	import racorr_pkg::*;

	localparam int NW  = ACC_WIDTH + FRAC_BITS;
	localparam int CW  = $clog2(NW + 1);
	localparam int QW  = VALUE_WIDTH + 3;

	logic [NW-1:0]        shreg_q;
	logic [ACC_WIDTH:0]   rem_q;
	logic [ACC_WIDTH-1:0] den_q;
	logic [QW-1:0]        quo_q;
	logic                 neg_q;
	logic [CW-1:0]        cnt_q;
	logic [ACC_WIDTH:0]   rem_sh;
	logic                 qb;
	logic [QW-1:0]        cap;
	logic [QW-1:0]        qsat;
	logic [ACC_WIDTH-1:0] mag;

	assign mag    = num[ACC_WIDTH-1] ? ACC_WIDTH'(-num) : ACC_WIDTH'(num);
	assign rem_sh = {rem_q[ACC_WIDTH-1:0], shreg_q[NW-1]};
	assign qb     = rem_sh >= {1'b0, den_q};
	assign cap    = QW'(1) << (VALUE_WIDTH + 2);

	// one quotient bit per cycle, quotient sticks at cap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= {mag, {FRAC_BITS{1'b0}}};
			rem_q   <= '0;
			den_q   <= den;
			quo_q   <= '0;
			neg_q   <= num[ACC_WIDTH-1];
		end else if (cnt_q != '0) begin
			shreg_q <= shreg_q << 1;
			rem_q   <= qb ? rem_sh - {1'b0, den_q} : rem_sh;
			if (quo_q < cap) quo_q <= {quo_q[QW-2:0], qb};
		end
	end

	assign busy = cnt_q != '0;

	// saturate magnitude to value range with sign
	always_comb begin
		qsat = quo_q;
		if (!neg_q && quo_q > QW'({1'b0, {(VALUE_WIDTH-1){1'b1}}}))
			qsat = QW'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
		if (neg_q && quo_q > QW'({1'b1, {(VALUE_WIDTH-1){1'b0}}}))
			qsat = QW'({1'b1, {(VALUE_WIDTH-1){1'b0}}});
		result = neg_q ? VALUE_WIDTH'(-qsat) : VALUE_WIDTH'(qsat);
	end
endmodule

// ===== sv/racorr_dp.sv =====
// ----------------------------------------------------------------------------
// racorr_dp
// Datapath: history and accumulator memories, shared MAC, divider, output.
// ----------------------------------------------------------------------------
module racorr_dp #(
	parameter int MAX_LAG      = 15,
	parameter int CHANNELS     = 8,
	parameter int SAMPLE_WIDTH = 16,
	parameter int ACC_WIDTH    = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  racorr_pkg::racorr_cmd_t         cmd,
	output racorr_pkg::racorr_sts_t         sts,
	input  logic [2:0]                      channel,
	input  logic signed [SAMPLE_WIDTH-1:0]  sample,
	input  logic                            slice_end,
	input  logic                            restart,
	input  logic [3:0]                      max_lag_q,
	input  logic                            normalize_q,
	input  logic                            skip_lag0_q,
	input  logic                            clear_all,
	output logic [2:0]                      out_channel,
	output logic [3:0]                      lag_index,
	output logic signed [racorr_pkg::VALUE_WIDTH-1:0] value,
	output logic                            last
);
	import racorr_pkg::*;

	localparam int LW  = $clog2(MAX_LAG + 1);
	localparam int CHW = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
	localparam int PW  = 2 * SAMPLE_WIDTH;
	localparam int DEP = CHANNELS * (MAX_LAG + 1);
	localparam int AW  = $clog2(DEP);

	// memories: history slot l holds x[n-l] (slot 0 unused), valid bits clear
	logic signed [SAMPLE_WIDTH-1:0] hist_mem [DEP];
	logic signed [ACC_WIDTH-1:0]    acc_mem  [DEP];
	logic [DEP-1:0]                 valid_q;

	logic [2:0]                     ch_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic                           se_q, rs_q;
	logic [LW-1:0]                  lag_q;
	logic [LW-1:0]                  lmax;
	logic [AW-1:0]                  addr;
	logic signed [ACC_WIDTH-1:0]    a0_q;
	logic signed [ACC_WIDTH-1:0]    rd_q;
	logic signed [ACC_WIDTH-1:0]    acc_rd_q;
	logic signed [SAMPLE_WIDTH-1:0] hist_rd_q;
	logic                           vld_rd_q;
	logic signed [SAMPLE_WIDTH-1:0] prev_q;   // sample carried to next slot
	logic signed [PW-1:0]           prod;
	logic signed [ACC_WIDTH-1:0]    acc_cur, acc_new, hi, lo;
	logic signed [ACC_WIDTH:0]      sum;
	logic signed [SAMPLE_WIDTH-1:0] h_cur;
	logic                           div_busy;
	logic signed [VALUE_WIDTH-1:0]  div_res;
	logic signed [VALUE_WIDTH-1:0]  raw_sat;
	logic                           norm_on;

	assign lmax = (32'(max_lag_q) > MAX_LAG) ? LW'(MAX_LAG) : LW'(max_lag_q);
	assign addr = AW'(32'(ch_q[CHW-1:0]) * (MAX_LAG + 1) + 32'(lag_q));

	// latch the item
	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			ch_q <= channel;
			x_q  <= sample;
			se_q <= slice_end;
			rs_q <= restart;
		end
	end

	// lag counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lag_q <= '0;
		else if (cmd.lag_clr) lag_q <= '0;
		else if (cmd.lag_inc) lag_q <= lag_q + 1'b1;
	end

	// valid bits stand in for zeroed entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= '0;
		else if (clear_all) valid_q <= '0;
		else if (cmd.clear_step) valid_q[addr] <= 1'b0;
		else if (cmd.mac_step) valid_q[addr] <= 1'b1;
	end

	// registered memory read at the lag counter
	always_ff @(posedge clk) begin
		if (cmd.mem_read) begin
			acc_rd_q  <= acc_mem[addr];
			hist_rd_q <= hist_mem[addr];
			vld_rd_q  <= valid_q[addr];
		end
	end

	assign acc_cur = vld_rd_q ? acc_rd_q : '0;
	assign h_cur   = vld_rd_q ? hist_rd_q : '0;

	// one multiply per lag step; lag 0 uses the sample itself
	assign prod = (lag_q == '0) ? PW'(x_q) * PW'(x_q) : PW'(x_q) * PW'(h_cur);
	assign hi   = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	assign lo   = {1'b1, {(ACC_WIDTH-1){1'b0}}};
	assign sum  = (ACC_WIDTH+1)'(acc_cur) + (ACC_WIDTH+1)'(prod);
	assign acc_new = (sum > (ACC_WIDTH+1)'(hi)) ? hi :
	                 (sum < (ACC_WIDTH+1)'(lo)) ? lo : sum[ACC_WIDTH-1:0];

	// accumulate and shift history one slot along the row
	always_ff @(posedge clk) begin
		if (cmd.mac_step) begin
			acc_mem[addr] <= acc_new;
			if (lag_q == '0) prev_q <= x_q;
			else begin
				hist_mem[addr] <= prev_q;
				prev_q <= h_cur;
			end
		end
		if (cmd.emit_read) begin
			rd_q <= acc_cur;
			if (lag_q == '0) a0_q <= acc_cur;
		end
	end

	assign norm_on = normalize_q && (lag_q == '0 ? (acc_cur > 0) : (a0_q > 0));

	racorr_div #(.ACC_WIDTH(ACC_WIDTH)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(rd_q), .den(a0_q), .busy(div_busy), .result(div_res)
	);

	// saturate raw sum into the value field
	always_comb begin
		if (ACC_WIDTH > VALUE_WIDTH) begin
			if (rd_q > (ACC_WIDTH)'(signed'({1'b0, {(VALUE_WIDTH-1){1'b1}}})))
				raw_sat = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
			else if (rd_q < -(ACC_WIDTH)'(signed'({1'b0, {(VALUE_WIDTH-1){1'b1}}})) - 1)
				raw_sat = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
			else raw_sat = VALUE_WIDTH'(rd_q);
		end else begin
			raw_sat = VALUE_WIDTH'(rd_q);
		end
	end

	// need_div registered at read time
	logic need_q;
	always_ff @(posedge clk) begin
		if (cmd.emit_read) need_q <= norm_on && !(lag_q == '0 && skip_lag0_q);
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_channel <= ch_q;
			lag_index   <= 4'(lag_q);
			value       <= need_q ? div_res : raw_sat;
			last        <= lag_q == lmax;
		end
	end

	assign sts.lag_done  = lag_q == lmax;
	assign sts.slice_end = se_q;
	assign sts.restart   = rs_q;
	assign sts.need_div  = need_q;
	assign sts.div_busy  = div_busy;
	assign sts.ch_ok     = 32'(channel) < CHANNELS;
endmodule

// ===== sv/racorr_ctrl.sv =====
// ----------------------------------------------------------------------------
// racorr_ctrl
// Controller: sequences clear, MAC over lags, division and result emission.
// ----------------------------------------------------------------------------
module racorr_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  logic                    out_stall,
	input  racorr_pkg::racorr_sts_t sts,
	output racorr_pkg::racorr_cmd_t cmd
);
	import racorr_pkg::*;

	racorr_state_t state_q, state_d;
	logic          ov_q, ov_d;
	logic          wait_q, wait_d;          // divider result pending

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ov_q       <= 1'b0;
			wait_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			ov_q       <= ov_d;
			wait_q     <= wait_d;
		end
	end

	assign out_valid = ov_q;
	assign in_stall  = state_q != ST_IDLE;

	// next state and commands
	always_comb begin
		state_d    = state_q;
		ov_d       = ov_q && out_stall;
		wait_d     = wait_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.ch_ok) begin
					cmd.take_item = 1'b1;
					cmd.lag_clr   = 1'b1;
					state_d       = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				// row clear up to the effective max lag when restarting
				if (!sts.restart) begin
					state_d = ST_MAC_RD;
				end else begin
					cmd.clear_step = 1'b1;
					if (sts.lag_done) begin
						cmd.lag_clr = 1'b1;
						state_d     = ST_MAC_RD;
					end else begin
						cmd.lag_inc = 1'b1;
					end
				end
			end
			ST_MAC_RD: begin
				cmd.mem_read = 1'b1;
				state_d = ST_MAC;
			end
			ST_MAC: begin
				cmd.mac_step = 1'b1;
				if (sts.lag_done) begin
					cmd.lag_clr = 1'b1;
					state_d = sts.slice_end ? ST_EMIT_RD : ST_IDLE;
				end else begin
					cmd.lag_inc = 1'b1;
					state_d = ST_MAC_RD;
				end
			end
			ST_EMIT_RD: begin
				cmd.mem_read = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit_read = 1'b1;
				state_d = ST_DIV;
				wait_d  = 1'b0;
			end
			ST_DIV: begin
				if (sts.need_div && !wait_q) begin
					cmd.div_start = 1'b1;
					wait_d = 1'b1;
				end else if (!sts.div_busy && !ov_d) begin
					cmd.out_load = 1'b1;
					ov_d = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!ov_d) begin
					if (sts.lag_done) begin
						state_d = ST_IDLE;
					end else begin
						cmd.lag_inc = 1'b1;
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== sv/running_autocorrelation.sv =====
// ----------------------------------------------------------------------------
// running_autocorrelation
// Per-channel running autocorrelation with optional normalization.
// ----------------------------------------------------------------------------
// channel | handshake              | payload
// in      | in_valid / in_stall    | channel, sample, slice_end, restart
// out     | out_valid / out_stall  | out_channel, lag_index, value, last
// cfg     | cfg_we                 | cfg_index, cfg_data
//
// With L the effective max lag, an item passes an accept step, a dispatch
// step, then a memory read and a multiply-accumulate for each lag 0 to L.
// A restart turns the dispatch step into a row clear of lags 0 to L.
// A slice end adds per lag two read steps, a load step and an output step,
// and with normalization a divider run for each lag that needs division.
// Reset clears all state through valid bits; no sweep is needed.
// A stalled output holds the controller; no new item is taken meanwhile.
// ----------------------------------------------------------------------------
module running_autocorrelation #(
	parameter int MAX_LAG      = 15,
	parameter int CHANNELS     = 8,
	parameter int SAMPLE_WIDTH = 16,
	parameter int ACC_WIDTH    = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     channel,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           slice_end,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     out_channel,
	output logic [3:0]                     lag_index,
	output logic signed [racorr_pkg::VALUE_WIDTH-1:0] value,
	output logic                           last,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [3:0]                     cfg_data
);
	import racorr_pkg::*;

	racorr_cmd_t cmd;
	racorr_sts_t sts;
	logic [3:0]  max_lag_q;
	logic        normalize_q, skip_lag0_q;
	logic        clear_all;
	logic [3:0]  idx;

	assign idx = {2'b00, cfg_index};
	assign clear_all = cfg_we &&
		(idx == REG_MAX_LAG || idx == REG_NORMALIZE || idx == REG_SKIP_LAG0);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_lag_q   <= 4'd15;
			normalize_q <= 1'b0;
			skip_lag0_q <= 1'b0;
		end else if (cfg_we) begin
			case (idx)
				REG_MAX_LAG:   max_lag_q   <= cfg_data;
				REG_NORMALIZE: normalize_q <= cfg_data[0];
				REG_SKIP_LAG0: skip_lag0_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	racorr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	racorr_dp #(
		.MAX_LAG(MAX_LAG), .CHANNELS(CHANNELS),
		.SAMPLE_WIDTH(SAMPLE_WIDTH), .ACC_WIDTH(ACC_WIDTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.channel(channel), .sample(sample), .slice_end(slice_end),
		.restart(restart), .max_lag_q(max_lag_q), .normalize_q(normalize_q),
		.skip_lag0_q(skip_lag0_q), .clear_all(clear_all),
		.out_channel(out_channel), .lag_index(lag_index), .value(value), .last(last)
	);
endmodule
